### hdl/awb_ogc_pkg.sv
// shared types, widths and helpers for the white-balance gain calculation pipeline
// no dependencies; every other file of the block but awb_ogc_div imports this package
package awb_ogc_pkg;

  localparam int unsigned RATIO_WIDTH  = 10;
  localparam int unsigned GAIN_W       = 16;
  localparam int unsigned UNITY_SHIFT  = 10;
  localparam int unsigned LIGHT_OFFSET = 512;
  localparam int unsigned LIGHT_SHIFT  = 10;

  // light + offset needs one bit more than the ratio, at least ten bits
  localparam int unsigned LIGHT_W  = (RATIO_WIDTH > 9) ? RATIO_WIDTH + 1 : 10;
  localparam int unsigned PROD_W   = RATIO_WIDTH + LIGHT_W;
  localparam int unsigned SCALED_W = PROD_W - LIGHT_SHIFT;
  // first quotient: unity * scaled value over a nonzero divisor
  localparam int unsigned Q1_W     = SCALED_W + UNITY_SHIFT;
  // second dividend: first quotient times a typical value
  localparam int unsigned P2_W     = Q1_W + RATIO_WIDTH;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'h0400;

  typedef struct packed {
    logic [RATIO_WIDTH-1:0] rg_meas;
    logic [RATIO_WIDTH-1:0] bg_meas;
    logic [RATIO_WIDTH-1:0] rg_light;
    logic [RATIO_WIDTH-1:0] bg_light;
  } in_item_t;

  typedef struct packed {
    logic [GAIN_W-1:0] red_gain;
    logic [GAIN_W-1:0] green_gain;
    logic [GAIN_W-1:0] blue_gain;
    logic              ratio_error;
  } out_item_t;

  // which gain takes the second quotient
  typedef enum logic [1:0] {
    QSEL_NONE,
    QSEL_RED,
    QSEL_BLUE
  } qsel_e;

  // context carried alongside the first divider
  typedef struct packed {
    logic                   err;
    logic                   gu;
    logic [RATIO_WIDTH-1:0] rgt;
    logic [RATIO_WIDTH-1:0] bgt;
    logic [SCALED_W-1:0]    rg_s;
    logic [SCALED_W-1:0]    bg_s;
  } front_t;

  // context carried alongside the second divider
  typedef struct packed {
    logic              err;
    qsel_e             qsel;
    logic [GAIN_W-1:0] r;
    logic [GAIN_W-1:0] g;
    logic [GAIN_W-1:0] b;
  } mid_t;

  function automatic logic [GAIN_W-1:0] sat_gain(input logic [P2_W-1:0] x);
    return (|x[P2_W-1:GAIN_W]) ? '1 : x[GAIN_W-1:0];
  endfunction

endpackage

### hdl/awb_ogc_front.sv
// input stage: light scaling, zero check, case decode and first divider operands
// depends on awb_ogc_pkg
module awb_ogc_front (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              en_i,
  input  logic                                              vld_i,
  input  awb_ogc_pkg::in_item_t                             item_i,
  input  logic [awb_ogc_pkg::RATIO_WIDTH-1:0]               rg_typ_i,
  input  logic [awb_ogc_pkg::RATIO_WIDTH-1:0]               bg_typ_i,
  output logic                                              vld_o,
  output awb_ogc_pkg::front_t                               front_o,
  output logic [1:0][awb_ogc_pkg::Q1_W-1:0]                 num_o,
  output logic [1:0][awb_ogc_pkg::SCALED_W-1:0]             den_o
);
  import awb_ogc_pkg::*;

  function automatic logic [SCALED_W-1:0] scale(input logic [RATIO_WIDTH-1:0] ratio,
                                                input logic [RATIO_WIDTH-1:0] light);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(ratio) * PROD_W'(LIGHT_W'(light) + LIGHT_W'(LIGHT_OFFSET));
    if (light == '0) begin
      return SCALED_W'(ratio);
    end
    return prod[PROD_W-1:LIGHT_SHIFT];
  endfunction

  logic                         vld_q;
  front_t                       front_d, front_q;
  logic [1:0][Q1_W-1:0]         num_d, num_q;
  logic [1:0][SCALED_W-1:0]     den_d, den_q;
  logic [SCALED_W-1:0]          rgt_x, bgt_x;

  always_comb begin
    front_d.rg_s = scale(item_i.rg_meas, item_i.rg_light);
    front_d.bg_s = scale(item_i.bg_meas, item_i.bg_light);
    // a zero typical value acts as one
    front_d.rgt  = (rg_typ_i == '0) ? RATIO_WIDTH'(1) : rg_typ_i;
    front_d.bgt  = (bg_typ_i == '0) ? RATIO_WIDTH'(1) : bg_typ_i;
    rgt_x        = SCALED_W'(front_d.rgt);
    bgt_x        = SCALED_W'(front_d.bgt);
    front_d.err  = (front_d.rg_s == '0) || (front_d.bg_s == '0);
    front_d.gu   = (front_d.rg_s < rgt_x) && (front_d.bg_s < bgt_x);
    // green unity: typical over measured, otherwise measured over typical
    if (front_d.gu) begin
      num_d[0] = {rgt_x, {UNITY_SHIFT{1'b0}}};
      den_d[0] = front_d.rg_s;
      num_d[1] = {bgt_x, {UNITY_SHIFT{1'b0}}};
      den_d[1] = front_d.bg_s;
    end else begin
      num_d[0] = {front_d.rg_s, {UNITY_SHIFT{1'b0}}};
      den_d[0] = rgt_x;
      num_d[1] = {front_d.bg_s, {UNITY_SHIFT{1'b0}}};
      den_d[1] = bgt_x;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      front_q <= front_d;
      num_q   <= num_d;
      den_q   <= den_d;
    end
  end

  assign vld_o   = vld_q;
  assign front_o = front_q;
  assign num_o   = num_q;
  assign den_o   = den_q;

endmodule

### hdl/awb_ogc_div.sv
// pipelined restoring divider, one quotient bit per register stage, with sideband
// generic widths; depends on nothing
module awb_ogc_div #(
  parameter int unsigned NUM_W  = 21,
  parameter int unsigned DEN_W  = 11,
  parameter int unsigned SIDE_W = 8,
  parameter int unsigned LANES  = 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             vld_i,
  input  logic [LANES-1:0][NUM_W-1:0]      num_i,
  input  logic [LANES-1:0][DEN_W-1:0]      den_i,
  input  logic [SIDE_W-1:0]                side_i,
  output logic                             vld_o,
  output logic [LANES-1:0][NUM_W-1:0]      quo_o,
  output logic [SIDE_W-1:0]                side_o
);

  // dividend bits shift out at the top while quotient bits shift in at the bottom
  logic [NUM_W-1:0]                vld_q;
  logic [LANES-1:0][NUM_W-1:0]     nq_q   [NUM_W];
  logic [SIDE_W-1:0]               side_q [NUM_W];
  logic [LANES-1:0][DEN_W-1:0]     rem_q  [NUM_W-1];
  logic [LANES-1:0][DEN_W-1:0]     den_q  [NUM_W-1];

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic                          vld_in;
    logic [LANES-1:0][NUM_W-1:0]   nq_in;
    logic [LANES-1:0][DEN_W-1:0]   rem_in;
    logic [LANES-1:0][DEN_W-1:0]   den_in;
    logic [SIDE_W-1:0]             side_in;
    logic [LANES-1:0][DEN_W:0]     tmp;
    logic [LANES-1:0]              ge;
    logic [LANES-1:0][NUM_W-1:0]   nq_d;

    if (s == 0) begin : g_first
      assign vld_in  = vld_i;
      assign nq_in   = num_i;
      assign rem_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign nq_in   = nq_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        tmp[l]  = {rem_in[l], nq_in[l][NUM_W-1]};
        ge[l]   = tmp[l] >= {1'b0, den_in[l]};
        nq_d[l] = {nq_in[l][NUM_W-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q[s]   <= nq_d;
        side_q[s] <= side_in;
      end
    end

    // the last stage only needs the quotient
    if (s < NUM_W - 1) begin : g_keep
      logic [LANES-1:0][DEN_W-1:0] rem_d;
      logic [LANES-1:0][DEN_W:0]   diff;

      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          diff[l]  = tmp[l] - {1'b0, den_in[l]};
          rem_d[l] = ge[l] ? diff[l][DEN_W-1:0] : tmp[l][DEN_W-1:0];
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= rem_d;
          den_q[s] <= den_in;
        end
      end
    end
  end

  assign vld_o  = vld_q[NUM_W-1];
  assign quo_o  = nq_q[NUM_W-1];
  assign side_o = side_q[NUM_W-1];

endmodule

### hdl/awb_ogc_mid.sv
// middle stage: picks the green gain, builds the second dividend and the partial gains
// depends on awb_ogc_pkg
module awb_ogc_mid (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  vld_i,
  input  logic [1:0][awb_ogc_pkg::Q1_W-1:0]     quo_i,
  input  awb_ogc_pkg::front_t                   front_i,
  output logic                                  vld_o,
  output logic [awb_ogc_pkg::P2_W-1:0]          num_o,
  output logic [awb_ogc_pkg::SCALED_W-1:0]      den_o,
  output awb_ogc_pkg::mid_t                     mid_o
);
  import awb_ogc_pkg::*;

  logic                    vld_q;
  logic [Q1_W-1:0]         gr, gb, g_sel;
  logic [RATIO_WIDTH-1:0]  t_sel;
  logic                    blue_unity;
  logic [P2_W-1:0]         num_d, num_q;
  logic [SCALED_W-1:0]     den_d, den_q;
  mid_t                    mid_d, mid_q;

  always_comb begin
    gr         = quo_i[0];
    gb         = quo_i[1];
    blue_unity = gb > gr;
    g_sel      = blue_unity ? gb : gr;
    t_sel      = blue_unity ? front_i.rgt : front_i.bgt;
    den_d      = blue_unity ? front_i.rg_s : front_i.bg_s;
    num_d      = P2_W'(g_sel) * P2_W'(t_sel);

    mid_d.err  = front_i.err;
    mid_d.qsel = QSEL_NONE;
    mid_d.r    = UNITY_GAIN;
    mid_d.g    = UNITY_GAIN;
    mid_d.b    = UNITY_GAIN;
    if (front_i.err) begin
      mid_d.qsel = QSEL_NONE;
    end else if (front_i.gu) begin
      mid_d.r = sat_gain(P2_W'(gr));
      mid_d.b = sat_gain(P2_W'(gb));
    end else if (blue_unity) begin
      mid_d.qsel = QSEL_RED;
      mid_d.g    = sat_gain(P2_W'(gb));
    end else begin
      mid_d.qsel = QSEL_BLUE;
      mid_d.g    = sat_gain(P2_W'(gr));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= num_d;
      den_q <= den_d;
      mid_q <= mid_d;
    end
  end

  assign vld_o = vld_q;
  assign num_o = num_q;
  assign den_o = den_q;
  assign mid_o = mid_q;

endmodule

### hdl/awb_ogc_out.sv
// output stage: saturates the second quotient, places it and holds the result register
// depends on awb_ogc_pkg
module awb_ogc_out (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              vld_i,
  input  logic [awb_ogc_pkg::P2_W-1:0]      quo_i,
  input  awb_ogc_pkg::mid_t                 mid_i,
  output logic                              out_valid_o,
  output awb_ogc_pkg::out_item_t            out_data_o
);
  import awb_ogc_pkg::*;

  logic              vld_q;
  logic [GAIN_W-1:0] q_sat;
  out_item_t         data_d, data_q;

  always_comb begin
    q_sat              = sat_gain(quo_i);
    data_d.red_gain    = mid_i.r;
    data_d.green_gain  = mid_i.g;
    data_d.blue_gain   = mid_i.b;
    data_d.ratio_error = mid_i.err;
    case (mid_i.qsel)
      QSEL_RED:  data_d.red_gain  = q_sat;
      QSEL_BLUE: data_d.blue_gain = q_sat;
      default:   data_d.ratio_error = mid_i.err;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = data_q;

endmodule

### hdl/awb_otp_gain_calc.sv
// white-balance gain calculation top level; uses awb_ogc_pkg and all awb_ogc_* stages
// throughput: one transaction per cycle; the whole pipeline holds while the result is stalled
// reset: asynchronous, clears all valid bits and loads both typical ratios with 256
module awb_otp_gain_calc (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  awb_ogc_pkg::in_item_t                  in_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output awb_ogc_pkg::out_item_t                 out_data_o,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [awb_ogc_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [awb_ogc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [awb_ogc_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                   pready
);
  import awb_ogc_pkg::*;

  localparam int unsigned REG_IDX_LSB = 2;
  localparam logic REG_RG_TYP = 1'b0;
  localparam logic REG_BG_TYP = 1'b1;
  localparam logic [RATIO_WIDTH-1:0] TYP_RESET = RATIO_WIDTH'(256);

  logic                       pipe_en;
  logic                       cfg_wr;
  logic [RATIO_WIDTH-1:0]     rg_typ_q, bg_typ_q;

  logic                       f_vld;
  front_t                     f_ctx;
  logic [1:0][Q1_W-1:0]       f_num;
  logic [1:0][SCALED_W-1:0]   f_den;

  logic                       d1_vld;
  logic [1:0][Q1_W-1:0]       d1_quo;
  front_t                     d1_ctx;

  logic                       m_vld;
  logic [P2_W-1:0]            m_num;
  logic [SCALED_W-1:0]        m_den;
  mid_t                       m_ctx;

  logic                       d2_vld;
  logic [P2_W-1:0]            d2_quo;
  mid_t                       d2_ctx;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rg_typ_q <= TYP_RESET;
      bg_typ_q <= TYP_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[REG_IDX_LSB])
        REG_RG_TYP: rg_typ_q <= pwdata[RATIO_WIDTH-1:0];
        REG_BG_TYP: bg_typ_q <= pwdata[RATIO_WIDTH-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[REG_IDX_LSB])
      REG_RG_TYP: prdata = APB_DATA_W'(rg_typ_q);
      REG_BG_TYP: prdata = APB_DATA_W'(bg_typ_q);
    endcase
  end

  // every stage moves together unless a finished result is held
  assign pipe_en    = !out_valid_o || !out_stall_i;
  assign in_stall_o = !pipe_en;

  awb_ogc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (pipe_en),
    .vld_i    (in_valid_i),
    .item_i   (in_data_i),
    .rg_typ_i (rg_typ_q),
    .bg_typ_i (bg_typ_q),
    .vld_o    (f_vld),
    .front_o  (f_ctx),
    .num_o    (f_num),
    .den_o    (f_den)
  );

  awb_ogc_div #(
    .NUM_W  (Q1_W),
    .DEN_W  (SCALED_W),
    .SIDE_W ($bits(front_t)),
    .LANES  (2)
  ) u_div1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .vld_i  (f_vld),
    .num_i  (f_num),
    .den_i  (f_den),
    .side_i (f_ctx),
    .vld_o  (d1_vld),
    .quo_o  (d1_quo),
    .side_o (d1_ctx)
  );

  awb_ogc_mid u_mid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .vld_i   (d1_vld),
    .quo_i   (d1_quo),
    .front_i (d1_ctx),
    .vld_o   (m_vld),
    .num_o   (m_num),
    .den_o   (m_den),
    .mid_o   (m_ctx)
  );

  awb_ogc_div #(
    .NUM_W  (P2_W),
    .DEN_W  (SCALED_W),
    .SIDE_W ($bits(mid_t)),
    .LANES  (1)
  ) u_div2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .vld_i  (m_vld),
    .num_i  (m_num),
    .den_i  (m_den),
    .side_i (m_ctx),
    .vld_o  (d2_vld),
    .quo_o  (d2_quo),
    .side_o (d2_ctx)
  );

  awb_ogc_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (pipe_en),
    .vld_i       (d2_vld),
    .quo_i       (d2_quo),
    .mid_i       (d2_ctx),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

`ifndef ASSERT_OFF
  a_err_unity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.ratio_error |->
      out_data_o.red_gain == UNITY_GAIN && out_data_o.green_gain == UNITY_GAIN &&
      out_data_o.blue_gain == UNITY_GAIN)
    else $error("ratio error transaction without unity gains");

  a_min_unity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_data_o.red_gain == UNITY_GAIN || out_data_o.green_gain == UNITY_GAIN ||
      out_data_o.blue_gain == UNITY_GAIN)
    else $error("no channel gain at unity");

  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while result register is empty");
`endif

endmodule
